// ----- rtl/erfc_pkg.sv -----
// Shared types and constants for the receive filter and classifier.
`timescale 1ns / 1ps
package erfc_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int POS_WIDTH       = $clog2(MAX_FRAME_BYTES + 1);
   localparam int HDR_BYTES       = 14;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] TYPE_IP  = 16'h0800;
   localparam logic [15:0] TYPE_ARP = 16'h0806;

   localparam logic PROTO_IP  = 1'b0;
   localparam logic PROTO_ARP = 1'b1;

   localparam logic [2:0] STATUS_IP      = 3'd0;
   localparam logic [2:0] STATUS_ARP     = 3'd1;
   localparam logic [2:0] STATUS_SHORT   = 3'd2;
   localparam logic [2:0] STATUS_REJECT  = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd4;

   typedef struct packed {
      logic        has_data;
      logic [7:0]  payload_byte;
      logic        protocol;
      logic        frame_end;
      logic [2:0]  frame_status;
      logic [31:0] packets_seen;
      logic [31:0] bytes_seen;
   } rsp_beat_type;

endpackage

// ----- rtl/erfc_front.sv -----
// Front part: byte parser, address filter, type classifier and frame counters.
`timescale 1ns / 1ps
module erfc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [47:0]           station_address,
   input  logic                  beat_accept,
   input  logic [7:0]            rx_byte,
   input  logic                  frame_last,
   output logic                  push,
   output erfc_pkg::rsp_beat_type push_beat
);
   import erfc_pkg::*;

   localparam logic [POS_WIDTH-1:0] POS_MAX = POS_WIDTH'(MAX_FRAME_BYTES);
   localparam logic [POS_WIDTH-1:0] POS_HDR = POS_WIDTH'(HDR_BYTES);
   localparam logic [POS_WIDTH-1:0] POS_ADDR_END = POS_WIDTH'(6);
   localparam logic [POS_WIDTH-1:0] POS_TYPE_HI  = POS_WIDTH'(12);
   localparam logic [POS_WIDTH-1:0] POS_TYPE_LO  = POS_WIDTH'(13);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 match_ff, match_in;
   logic                 group_ff, group_in;
   logic [15:0]          type_ff, type_in;
   logic [31:0]          pkt_cnt_ff, pkt_cnt_in;
   logic [31:0]          byte_cnt_ff, byte_cnt_in;

   logic                 in_window;
   logic [7:0]           want_byte;
   logic                 deliver;
   logic                 addr_ok;
   logic [2:0]           status;

   always_comb begin
      case (pos_ff[2:0])
         3'd0:    want_byte = station_address[47:40];
         3'd1:    want_byte = station_address[39:32];
         3'd2:    want_byte = station_address[31:24];
         3'd3:    want_byte = station_address[23:16];
         3'd4:    want_byte = station_address[15:8];
         default: want_byte = station_address[7:0];
      endcase
   end

   always_comb begin
      in_window = pos_ff < POS_MAX;
      pos_in    = pos_ff;
      match_in  = match_ff;
      group_in  = group_ff;
      type_in   = type_ff;
      deliver   = 1'b0;
      if (in_window) begin
         pos_in = pos_ff + POS_WIDTH'(1);
         if (pos_ff < POS_ADDR_END) begin
            if (rx_byte != want_byte) match_in = 1'b0;
            if (pos_ff == '0) group_in = rx_byte[0];
         end else if (pos_ff == POS_TYPE_HI) begin
            type_in = {rx_byte, 8'h00};
         end else if (pos_ff == POS_TYPE_LO) begin
            type_in = {type_ff[15:8], rx_byte};
         end else if (pos_ff >= POS_HDR && (match_ff || group_ff)) begin
            deliver = (type_ff == TYPE_IP) || (type_ff == TYPE_ARP);
         end
      end

      addr_ok     = match_in || group_in;
      pkt_cnt_in  = pkt_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      if (pos_in < POS_HDR) begin
         status = STATUS_SHORT;
      end else if (!addr_ok) begin
         status = STATUS_REJECT;
      end else begin
         pkt_cnt_in  = pkt_cnt_ff + 32'd1;
         byte_cnt_in = byte_cnt_ff + 32'(pos_in) - 32'(HDR_BYTES);
         if (type_in == TYPE_IP)       status = STATUS_IP;
         else if (type_in == TYPE_ARP) status = STATUS_ARP;
         else                          status = STATUS_UNKNOWN;
      end

      push_beat = '0;
      if (deliver) begin
         push_beat.has_data     = 1'b1;
         push_beat.payload_byte = rx_byte;
         push_beat.protocol     = (type_ff == TYPE_ARP) ? PROTO_ARP : PROTO_IP;
      end
      if (frame_last) begin
         push_beat.frame_end    = 1'b1;
         push_beat.frame_status = status;
         push_beat.packets_seen = pkt_cnt_in;
         push_beat.bytes_seen   = byte_cnt_in;
      end
      push = beat_accept && (deliver || frame_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         match_ff    <= 1'b1;
         group_ff    <= 1'b0;
         type_ff     <= '0;
         pkt_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
      end else if (beat_accept) begin
         if (frame_last) begin
            // frame done: counters commit, per-frame state restarts
            pos_ff      <= '0;
            match_ff    <= 1'b1;
            group_ff    <= 1'b0;
            type_ff     <= '0;
            pkt_cnt_ff  <= pkt_cnt_in;
            byte_cnt_ff <= byte_cnt_in;
         end else begin
            pos_ff   <= pos_in;
            match_ff <= match_in;
            group_ff <= group_in;
            type_ff  <= type_in;
         end
      end
   end

endmodule

// ----- rtl/erfc_queue.sv -----
// Short result queue between the front and back parts.
`timescale 1ns / 1ps
module erfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  erfc_pkg::rsp_beat_type push_beat,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output erfc_pkg::rsp_beat_type head_beat
);
   import erfc_pkg::*;

   rsp_beat_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_beat = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + QCNT_WIDTH'(1);
      else if (pop && !push) count_in = count_ff - QCNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_beat;
   end

endmodule

// ----- rtl/erfc_back.sv -----
// Back part: output register that drains the queue onto the result channel.
`timescale 1ns / 1ps
module erfc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  erfc_pkg::rsp_beat_type head_beat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output erfc_pkg::rsp_beat_type rsp_beat
);
   import erfc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff;

   // load a new beat when the register is empty or being drained
   assign pop       = not_empty && (!valid_ff || rsp_ready);
   assign valid_in  = pop || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) beat_ff <= head_beat;
   end

endmodule

// ----- rtl/ethernet_rx_filter_and_classify_unit.sv -----
// Top level: Ethernet receive address filter and classifier.
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+------------------------------
//  req     | req_valid/req_ready            | in        | one frame byte + last marker
//  rsp     | rsp_valid/rsp_ready            | out       | payload byte and/or frame status
//  csr     | csr_valid/csr_ready            | in        | 48-bit station address
//
// One byte per cycle sustained while the queue has room; the parser updates its
// state in the cycle a byte is taken, the result enters the queue at that edge
// and moves into the output register, raising rsp_valid, once that register is
// empty or being drained. A four-entry queue decouples the parser from rsp
// stalls; req_ready drops only while that queue is full. Synchronous reset
// clears the parser state, counters and station address. csr is always ready.
`timescale 1ns / 1ps
module ethernet_rx_filter_and_classify_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [47:0] csr_station_address,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_data,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_protocol,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_frame_status,
   output logic [31:0] rsp_packets_seen,
   output logic [31:0] rsp_bytes_seen
);
   import erfc_pkg::*;

   logic [47:0]  station_ff;
   logic         req_accept;
   logic         push, full, pop, not_empty;
   rsp_beat_type push_beat, head_beat, out_beat;

   assign csr_ready  = 1'b1;
   assign req_ready  = !full;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset)          station_ff <= '0;
      else if (csr_valid) station_ff <= csr_station_address;
   end

   erfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .station_address (station_ff),
      .beat_accept     (req_accept),
      .rx_byte         (req_rx_byte),
      .frame_last      (req_frame_last),
      .push            (push),
      .push_beat       (push_beat)
   );

   erfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_beat (head_beat)
   );

   erfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head_beat (head_beat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (out_beat)
   );

   assign rsp_has_data     = out_beat.has_data;
   assign rsp_payload_byte = out_beat.payload_byte;
   assign rsp_protocol     = out_beat.protocol;
   assign rsp_frame_end    = out_beat.frame_end;
   assign rsp_frame_status = out_beat.frame_status;
   assign rsp_packets_seen = out_beat.packets_seen;
   assign rsp_bytes_seen   = out_beat.bytes_seen;

endmodule

// ----- test/ethernet_rx_filter_and_classify_checker.sv -----
// Checker for the receive filter: predicts result beats and compares them as they leave.
`timescale 1ns / 1ps
module ethernet_rx_filter_and_classify_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [47:0] csr_station_address,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_has_data,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_protocol,
   input  logic        rsp_frame_end,
   input  logic [2:0]  rsp_frame_status,
   input  logic [31:0] rsp_packets_seen,
   input  logic [31:0] rsp_bytes_seen,
   output int          mismatch_count,
   output int          pending_beats,
   output int          delivered_count,
   output int          report_count
);
   import erfc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   rsp_beat_type predicted_beats[$];

   logic [47:0] station_addr;
   int          frame_pos;
   logic        addr_match;
   logic        group_dest;
   logic [15:0] ether_type;
   logic [31:0] packets_total;
   logic [31:0] payload_total;

   function automatic void restart_frame();
      frame_pos  = 0;
      addr_match = 1'b1;
      group_dest = 1'b0;
      ether_type = '0;
   endfunction

   // Advances the filter state by one frame byte; returns 1 when a beat results.
   function automatic bit classify_byte(input logic [7:0] value, input logic last,
                                        output rsp_beat_type beat);
      logic       deliver;
      logic       proto;
      logic [2:0] status;
      deliver = 1'b0;
      proto   = PROTO_IP;
      beat    = '0;
      if (frame_pos < MAX_FRAME_BYTES) begin
         if (frame_pos < 6) begin
            if (value != station_addr[47 - 8 * frame_pos -: 8])
               addr_match = 1'b0;
            if (frame_pos == 0)
               group_dest = value[0];
         end else if (frame_pos == 12) begin
            ether_type = {value, 8'h00};
         end else if (frame_pos == 13) begin
            ether_type[7:0] = value;
         end else if (frame_pos >= HDR_BYTES && (addr_match || group_dest)) begin
            if (ether_type == TYPE_IP) begin
               deliver = 1'b1;
               proto   = PROTO_IP;
            end else if (ether_type == TYPE_ARP) begin
               deliver = 1'b1;
               proto   = PROTO_ARP;
            end
         end
         frame_pos++;
      end
      if (!deliver && !last)
         return 1'b0;
      if (deliver) begin
         beat.has_data     = 1'b1;
         beat.payload_byte = value;
         beat.protocol     = proto;
      end
      if (last) begin
         if (frame_pos < HDR_BYTES) begin
            status = STATUS_SHORT;
         end else if (!(addr_match || group_dest)) begin
            status = STATUS_REJECT;
         end else begin
            packets_total = packets_total + 32'd1;
            payload_total = payload_total + 32'(frame_pos - HDR_BYTES);
            if (ether_type == TYPE_IP)
               status = STATUS_IP;
            else if (ether_type == TYPE_ARP)
               status = STATUS_ARP;
            else
               status = STATUS_UNKNOWN;
         end
         beat.frame_end    = 1'b1;
         beat.frame_status = status;
         beat.packets_seen = packets_total;
         beat.bytes_seen   = payload_total;
         restart_frame();
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rsp_beat_type seen;
      rsp_beat_type want;
      if (reset) begin
         station_addr  = '0;
         packets_total = '0;
         payload_total = '0;
         restart_frame();
         predicted_beats.delete();
      end else begin
         // outgoing beat belongs to an earlier byte, so check it before predicting
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_has_data, rsp_payload_byte, rsp_protocol, rsp_frame_end,
                    rsp_frame_status, rsp_packets_seen, rsp_bytes_seen};
            if (predicted_beats.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("mismatch at %0t ns: result beat with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = predicted_beats.pop_front();
               if (seen.has_data !== want.has_data || seen.payload_byte !== want.payload_byte
                   || seen.protocol !== want.protocol || seen.frame_end !== want.frame_end
                   || seen.frame_status !== want.frame_status
                   || seen.packets_seen !== want.packets_seen
                   || seen.bytes_seen !== want.bytes_seen) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("mismatch at %0t ns: expected data=%0b byte=%02h proto=%0b end=%0b",
                              $time, want.has_data, want.payload_byte, want.protocol,
                              want.frame_end);
                     $display("   status=%0d packets=%0d bytes=%0d; got data=%0b byte=%02h",
                              want.frame_status, want.packets_seen, want.bytes_seen,
                              seen.has_data, seen.payload_byte);
                     $display("   proto=%0b end=%0b status=%0d packets=%0d bytes=%0d",
                              seen.protocol, seen.frame_end, seen.frame_status,
                              seen.packets_seen, seen.bytes_seen);
                  end
                  mismatch_count++;
               end
               if (want.has_data)
                  delivered_count++;
               if (want.frame_end)
                  report_count++;
            end
         end
         if (req_valid && req_ready) begin
            if (classify_byte(req_rx_byte, req_frame_last, want))
               predicted_beats.push_back(want);
         end
         if (csr_valid && csr_ready)
            station_addr = csr_station_address;
      end
      pending_beats = predicted_beats.size();
   end

endmodule

// ----- test/ethernet_rx_filter_and_classify_unit_test.sv -----
// Testbench top: drives frames and station addresses into the receive filter, gives the verdict.
`timescale 1ns / 1ps
module ethernet_rx_filter_and_classify_unit_test;
   import erfc_pkg::*;

   localparam int          WATCHDOG_LIMIT         = 2000;
   localparam int          SETTLE_CYCLES          = 4;
   localparam int          RANDOM_BYTES_PER_PHASE = 130;
   localparam int          PHASES                 = 4;
   localparam logic [47:0] BROADCAST              = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] HOME_ADDRESS           = 48'h02_1A_2B_3C_4D_5E;
   localparam logic [47:0] GROUP_BIT              = 48'h01_00_00_00_00_00;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [47:0] csr_station_address;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        req_frame_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_has_data;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_protocol;
   logic        rsp_frame_end;
   logic [2:0]  rsp_frame_status;
   logic [31:0] rsp_packets_seen;
   logic [31:0] rsp_bytes_seen;

   int          mismatch_count;
   int          pending_beats;
   int          delivered_count;
   int          report_count;
   int          bytes_sent;
   int          frames_sent;
   int          settings_used;
   int          idle_cycles;
   logic [47:0] station;
   bit          calm;

   ethernet_rx_filter_and_classify_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_station_address (csr_station_address),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_frame_last      (req_frame_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_has_data        (rsp_has_data),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_protocol        (rsp_protocol),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_packets_seen    (rsp_packets_seen),
      .rsp_bytes_seen      (rsp_bytes_seen)
   );

   ethernet_rx_filter_and_classify_checker filter_check (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_station_address (csr_station_address),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_frame_last      (req_frame_last),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_has_data        (rsp_has_data),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_protocol        (rsp_protocol),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_packets_seen    (rsp_packets_seen),
      .rsp_bytes_seen      (rsp_bytes_seen),
      .mismatch_count      (mismatch_count),
      .pending_beats       (pending_beats),
      .delivered_count     (delivered_count),
      .report_count        (report_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ends the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: ready in random bursts, stalls in random bursts, always ready once calm.
   initial begin : rsp_pacing
      int span;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ready = 1'b1;
            span = calm ? 1 : $urandom_range(1, 30);
         end else begin
            rsp_ready = 1'b0;
            span = $urandom_range(1, 18);
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   // All driving tasks start and end on a falling edge.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_rx_byte    = value;
      req_frame_last = last;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [47:0] dest, input logic [15:0] ether_type,
                             input int total_len, input bit extremes);
      logic [7:0] value;
      for (int i = 0; i < total_len; i++) begin
         if (i < 6)
            value = dest[47 - 8 * i -: 8];
         else if (i < 12)
            value = 8'($urandom);
         else if (i == 12)
            value = ether_type[15:8];
         else if (i == 13)
            value = ether_type[7:0];
         else if (extremes)
            value = (i % 2 == 1) ? 8'hFF : 8'h00;
         else
            value = 8'($urandom);
         send_byte(value, i == total_len - 1);
      end
      frames_sent++;
   endtask

   task automatic random_frame();
      logic [47:0] dest;
      logic [15:0] ether_type;
      int          pick;
      int          total_len;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         dest = station;
      else if (pick < 65)
         dest = BROADCAST;
      else if (pick < 75)
         dest = {16'($urandom), $urandom} | GROUP_BIT;
      else if (pick < 90)
         dest = station ^ (48'd1 << $urandom_range(0, 47));
      else
         dest = {16'($urandom), $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 45)
         ether_type = TYPE_IP;
      else if (pick < 75)
         ether_type = TYPE_ARP;
      else if (pick < 85)
         ether_type = TYPE_ARP ^ (16'd1 << $urandom_range(0, 15));
      else
         ether_type = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8)
         total_len = $urandom_range(1, HDR_BYTES - 1);
      else if (pick < 13)
         total_len = HDR_BYTES;
      else if (pick < 16)
         total_len = HDR_BYTES + $urandom_range(41, 300);
      else
         total_len = HDR_BYTES + $urandom_range(1, 40);
      send_frame(dest, ether_type, total_len, 1'b0);
   endtask

   // Sender holds off until every predicted beat has left, then lets the block settle.
   task automatic quiesce();
      req_valid = 1'b0;
      wait (pending_beats == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_station(input logic [47:0] addr);
      csr_station_address = addr;
      csr_valid           = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      station   = addr;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [47:0] phase_addr [PHASES];
      int          phase_start;
      reset               = 1'b1;
      calm                = 1'b0;
      csr_valid           = 1'b0;
      csr_station_address = '0;
      req_valid           = 1'b0;
      req_rx_byte         = '0;
      req_frame_last      = 1'b0;
      station             = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_station(HOME_ADDRESS);
      // short frames, including a short broadcast
      send_frame(HOME_ADDRESS, TYPE_IP, 1, 1'b0);
      send_frame(HOME_ADDRESS, TYPE_IP, HDR_BYTES - 1, 1'b0);
      send_frame(BROADCAST, TYPE_ARP, 7, 1'b0);
      // header only: counted with zero payload
      send_frame(HOME_ADDRESS, TYPE_ARP, HDR_BYTES, 1'b0);
      send_frame(HOME_ADDRESS, TYPE_IP, HDR_BYTES, 1'b0);
      send_frame(HOME_ADDRESS, TYPE_IP, HDR_BYTES + 4, 1'b1);
      send_frame(BROADCAST, TYPE_ARP, HDR_BYTES + 3, 1'b1);
      send_frame(48'h01_00_5E_00_00_FB, TYPE_IP, HDR_BYTES + 2, 1'b0);
      // address misses in the last and in the first byte
      send_frame(HOME_ADDRESS ^ 48'h1, TYPE_IP, HDR_BYTES + 3, 1'b0);
      send_frame(HOME_ADDRESS ^ 48'h80_00_00_00_00_00, TYPE_ARP, HDR_BYTES + 2, 1'b0);
      // unknown types, byte-swapped ARP among them
      send_frame(HOME_ADDRESS, 16'hFFFF, HDR_BYTES + 2, 1'b1);
      send_frame(HOME_ADDRESS, 16'h0608, HDR_BYTES + 2, 1'b0);
      send_frame(HOME_ADDRESS, 16'h0000, HDR_BYTES + 1, 1'b0);
      send_frame(HOME_ADDRESS ^ 48'h1, 16'h1234, HDR_BYTES + 2, 1'b0);
      // oversized: bytes past the window are neither delivered nor counted
      send_frame(HOME_ADDRESS, TYPE_IP, MAX_FRAME_BYTES + 12, 1'b0);
      send_frame(BROADCAST, 16'h86DD, MAX_FRAME_BYTES + 3, 1'b0);

      phase_addr[0] = 48'h0;
      phase_addr[1] = BROADCAST;
      phase_addr[2] = {16'($urandom), $urandom} & ~GROUP_BIT;
      phase_addr[3] = {16'($urandom), $urandom};
      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         write_station(phase_addr[p]);
         calm        = (p == PHASES - 1);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE)
            random_frame();
      end

      req_valid = 1'b0;
      wait (pending_beats == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d frames (%0d bytes) under %0d station addresses: short, header-only,",
               frames_sent, bytes_sent, settings_used);
      $display("oversized, rejected, multicast and unknown-type frames; %0d payload bytes, %0d reports.",
               delivered_count, report_count);
      if (mismatch_count == 0 && pending_beats == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
